[design/tcc_pkg.sv]
// Shared types and constants of the theremin capture conditioner.
// Used by the configuration registers, the controller, the datapath and the top level.
// Depends on nothing else.
package tcc_pkg;

  localparam int CAPTURE_BITS = 16;
  localparam int AVG_W        = CAPTURE_BITS + 1;
  localparam int MAX_W        = (CAPTURE_BITS > 16) ? CAPTURE_BITS : 16;
  localparam int LIN_W        = MAX_W + 2;

  localparam logic [CAPTURE_BITS-1:0] CAP_MAX = '1;

  localparam int PITCH_OFS     = 2048;
  localparam int PITCH_MAX     = 16383;
  localparam int VOL_FLOOR_RAW = 5000;
  localparam int VOL_MAX       = 4095;
  localparam int VOL_POT_OFS   = 1024;
  localparam int LOG_OCT       = 819;
  localparam int LOG_KNEE      = 512;
  localparam int LOG_BIAS      = 48;
  localparam int LOG_NORM_MAX  = 1023;

  localparam logic [CAPTURE_BITS-1:0] VOL_FLOOR =
    (CAPTURE_BITS >= 13) ? CAPTURE_BITS'(VOL_FLOOR_RAW) : CAP_MAX;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CV_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_OFF    = 3'd4;

  localparam logic [1:0] CV_OFF    = 2'd0;
  localparam logic [1:0] CV_LINEAR = 2'd1;
  localparam logic [1:0] CV_LOG    = 2'd2;

  localparam logic [6:0] GATE_ON_RESET  = 7'd64;
  localparam logic [6:0] GATE_OFF_RESET = 7'd32;

  typedef struct packed {
    logic [15:0] pitch_base;
    logic [15:0] volume_base;
    logic [1:0]  cv_mode;
    logic [6:0]  gate_on_level;
    logic [6:0]  gate_off_level;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic upd_avg;
    logic calc_lin;
    logic norm_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic repeat_hit;
    logic norm_more;
  } dp_sts_t;

endpackage

[design/tcc_cfg_regs.sv]
// Configuration register file of the theremin capture conditioner.
// Depends on tcc_pkg for register indexes, reset values and the cfg_t bundle.
module tcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_DAT_W-1:0] cfg_data,
  output tcc_pkg::cfg_t                 cfg
);
  import tcc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pitch_base     <= '0;
      cfg_r.volume_base    <= '0;
      cfg_r.cv_mode        <= CV_OFF;
      cfg_r.gate_on_level  <= GATE_ON_RESET;
      cfg_r.gate_off_level <= GATE_OFF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PITCH_BASE:  cfg_r.pitch_base     <= cfg_data;
        REG_VOLUME_BASE: cfg_r.volume_base    <= cfg_data;
        REG_CV_MODE:     cfg_r.cv_mode        <= cfg_data[1:0];
        REG_GATE_ON:     cfg_r.gate_on_level  <= cfg_data[6:0];
        REG_GATE_OFF:    cfg_r.gate_off_level <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

[design/tcc_ctrl.sv]
// Controller state machine of the theremin capture conditioner.
// Sequences the datapath through averaging, linearization, log normalization and output.
// Depends on tcc_pkg for the command and status bundles.
module tcc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output tcc_pkg::dp_cmd_t cmd,
  input  tcc_pkg::dp_sts_t sts
);
  import tcc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_AVG, S_LIN, S_NORM, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_AVG;
        end
      end
      S_AVG: begin
        if (sts.repeat_hit) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.upd_avg = 1'b1;
          state_nxt   = S_LIN;
        end
      end
      S_LIN: begin
        cmd.calc_lin = 1'b1;
        state_nxt    = S_NORM;
      end
      S_NORM: begin
        if (sts.norm_more) begin
          cmd.norm_step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled result");

  a_accept_to_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_AVG))
    else $error("accepted transaction did not start averaging");

  a_norm_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NORM && !sts.norm_more) |=> (state_r == S_DONE))
    else $error("normalization did not finish");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the output state");

endmodule

[design/tcc_datapath.sv]
// Datapath of the theremin capture conditioner: averages, linearization, clamp,
// log normalization, gate hysteresis and the result register.
// Depends on tcc_pkg; driven by tcc_ctrl through dp_cmd_t and dp_sts_t.
module tcc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  tcc_pkg::cfg_t    cfg,
  input  tcc_pkg::dp_cmd_t cmd,
  output tcc_pkg::dp_sts_t sts,
  input  logic             in_func,
  input  logic [15:0]      in_capture,
  input  logic [9:0]       in_pitch_pot,
  input  logic [9:0]       in_volume_pot,
  input  logic [1:0]       in_octave_shift,
  input  logic             in_audio_on,
  output logic             out_kind,
  output logic [13:0]      out_linear_value,
  output logic [13:0]      out_wave_step,
  output logic             out_step_valid,
  output logic [11:0]      out_cv_value,
  output logic             out_cv_valid,
  output logic [15:0]      out_volume_level,
  output logic             out_gate
);
  import tcc_pkg::*;

  logic                    func_r;
  logic [CAPTURE_BITS-1:0] cap_r;
  logic [9:0]              ppot_r, vpot_r;
  logic [1:0]              shift_r;
  logic                    audio_r;

  logic [CAPTURE_BITS-1:0] pitch_avg_r, pitch_avg_nxt;
  logic [CAPTURE_BITS-1:0] vol_avg_r, vol_avg_nxt;
  logic [CAPTURE_BITS-1:0] last_vol_r, last_vol_nxt;
  logic                    seen_r, seen_nxt;
  logic                    gate_r, gate_nxt;

  logic [13:0] lin_r, lin_nxt;
  logic [13:0] norm_t_r, norm_t_nxt;
  logic [11:0] oct_r, oct_nxt;

  logic                    kind_r, step_ok_r, cv_ok_r, gate_out_r;
  logic [13:0]             lin_out_r, step_r;
  logic [11:0]             cv_r;
  logic [15:0]             level_r;

  logic [CAPTURE_BITS-1:0] avg_sel, x_sel, new_avg;
  logic signed [AVG_W-1:0] s_diff, s_q;
  logic signed [LIN_W-1:0] p_sum, v_diff, v_adj, v_half, v_sum;
  logic [13:0]             p_lin, v_lin;
  logic                    cv_on;
  logic [9:0]              t10;
  logic [8:0]              knee;
  logic [18:0]             prod;
  logic signed [13:0]      log_r;
  logic [11:0]             log_cv;
  logic [7:0]              t8;
  logic [15:0]             level;
  logic [6:0]              half7;
  logic                    step_ok, cv_ok;
  logic [11:0]             cv;

  assign sts.repeat_hit = func_r && seen_r && (cap_r == last_vol_r);
  assign sts.norm_more  = (norm_t_r > 14'(LOG_NORM_MAX));

  assign cv_on = (cfg.cv_mode == CV_LINEAR) || (cfg.cv_mode == CV_LOG);

  always_comb begin
    avg_sel = func_r ? vol_avg_r : pitch_avg_r;
    x_sel   = cap_r;
    if (func_r && (cap_r < VOL_FLOOR)) begin
      x_sel = VOL_FLOOR;
    end
    s_diff  = signed'(AVG_W'(x_sel)) - signed'(AVG_W'(avg_sel));
    s_q     = s_diff >>> 2;
    new_avg = CAPTURE_BITS'(signed'(AVG_W'(avg_sel)) + s_q);
  end

  always_comb begin
    p_sum = signed'(LIN_W'(cfg.pitch_base)) - signed'(LIN_W'(pitch_avg_r))
          + signed'(LIN_W'(PITCH_OFS)) - signed'(LIN_W'({ppot_r, 2'b00}));
    if (p_sum < 0) begin
      p_lin = '0;
    end else if (p_sum > signed'(LIN_W'(PITCH_MAX))) begin
      p_lin = 14'(PITCH_MAX);
    end else begin
      p_lin = p_sum[13:0];
    end

    v_diff = signed'(LIN_W'(cfg.volume_base)) - signed'(LIN_W'(vol_avg_r));
    v_adj  = v_diff + signed'(LIN_W'(v_diff[LIN_W-1]));
    v_half = v_adj >>> 1;
    v_sum  = signed'(LIN_W'(VOL_MAX)) - v_half + signed'(LIN_W'({vpot_r, 2'b00}))
           - signed'(LIN_W'(VOL_POT_OFS));
    if (v_sum < 0) begin
      v_lin = '0;
    end else if (v_sum > signed'(LIN_W'(VOL_MAX))) begin
      v_lin = 14'(VOL_MAX);
    end else begin
      v_lin = v_sum[13:0];
    end
  end

  always_comb begin
    t10    = norm_t_r[9:0];
    knee   = (t10 > 10'(LOG_KNEE)) ? 9'(t10 - 10'(LOG_KNEE)) : 9'd0;
    prod   = 19'(knee) * 19'(LOG_OCT);
    log_r  = signed'(14'(oct_r)) + signed'(14'(prod[18:9])) - signed'(14'(LOG_BIAS));
    log_cv = (log_r < 0) ? 12'd0 : log_r[11:0];

    t8     = lin_r[11:4];
    level  = 16'(16'(t8) * (16'(t8) + 16'd2));
    half7  = t8[7:1];
  end

  always_comb begin
    pitch_avg_nxt = pitch_avg_r;
    vol_avg_nxt   = vol_avg_r;
    last_vol_nxt  = last_vol_r;
    seen_nxt      = seen_r;
    gate_nxt      = gate_r;
    lin_nxt       = lin_r;
    norm_t_nxt    = norm_t_r;
    oct_nxt       = oct_r;
    step_ok       = 1'b0;
    cv_ok         = 1'b0;
    cv            = '0;

    if (cmd.upd_avg) begin
      if (func_r) begin
        vol_avg_nxt  = new_avg;
        last_vol_nxt = cap_r;
        seen_nxt     = 1'b1;
      end else begin
        pitch_avg_nxt = new_avg;
      end
    end

    if (cmd.calc_lin) begin
      lin_nxt    = func_r ? v_lin : p_lin;
      norm_t_nxt = func_r ? v_lin : p_lin;
      oct_nxt    = '0;
    end

    if (cmd.norm_step) begin
      norm_t_nxt = norm_t_r >> 1;
      oct_nxt    = oct_r + 12'(LOG_OCT);
    end

    if (func_r) begin
      if (cv_on) begin
        cv    = lin_r[11:0];
        cv_ok = 1'b1;
        if (cmd.load_out) begin
          if (!gate_r && (half7 >= cfg.gate_on_level)) begin
            gate_nxt = 1'b1;
          end else if (gate_r && (half7 <= cfg.gate_off_level)) begin
            gate_nxt = 1'b0;
          end
        end
      end
    end else if (audio_r) begin
      step_ok = 1'b1;
      if (cv_on && (MAX_W'(lin_r) != MAX_W'(cap_r))) begin
        cv_ok = 1'b1;
        cv    = (cfg.cv_mode == CV_LINEAR) ? lin_r[13:2] : log_cv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_avg_r <= '0;
      vol_avg_r   <= '0;
      last_vol_r  <= '0;
      seen_r      <= 1'b0;
      gate_r      <= 1'b0;
    end else begin
      pitch_avg_r <= pitch_avg_nxt;
      vol_avg_r   <= vol_avg_nxt;
      last_vol_r  <= last_vol_nxt;
      seen_r      <= seen_nxt;
      gate_r      <= gate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r  <= in_func;
      cap_r   <= CAPTURE_BITS'(in_capture);
      ppot_r  <= in_pitch_pot;
      vpot_r  <= in_volume_pot;
      shift_r <= in_octave_shift;
      audio_r <= in_audio_on;
    end
    lin_r    <= lin_nxt;
    norm_t_r <= norm_t_nxt;
    oct_r    <= oct_nxt;
    if (cmd.load_out) begin
      kind_r     <= func_r;
      lin_out_r  <= lin_r;
      step_r     <= step_ok ? (lin_r >> shift_r) : 14'd0;
      step_ok_r  <= step_ok;
      cv_r       <= cv;
      cv_ok_r    <= cv_ok;
      level_r    <= (func_r && audio_r) ? level : 16'd0;
      gate_out_r <= gate_nxt;
    end
  end

  assign out_kind         = kind_r;
  assign out_linear_value = lin_out_r;
  assign out_wave_step    = step_r;
  assign out_step_valid   = step_ok_r;
  assign out_cv_value     = cv_r;
  assign out_cv_valid     = cv_ok_r;
  assign out_volume_level = level_r;
  assign out_gate         = gate_out_r;

endmodule

[design/theremin_capture_conditioner.sv]
// Theremin capture conditioner: a transaction is accepted only while the controller is idle.
// An accepted transaction passes through the averaging, linearization, log normalization
// (one octave shift per step, 0 to 4 shifts) and output states; the output state waits while
// a result is stalled; a repeated volume capture returns to idle with no result. Synchronous
// active-low reset clears averages, gate and volume history and resets config registers.
// Depends on tcc_pkg, tcc_cfg_regs, tcc_ctrl and tcc_datapath.
module theremin_capture_conditioner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [15:0]                   in_capture,
  input  logic [9:0]                    in_pitch_pot,
  input  logic [9:0]                    in_volume_pot,
  input  logic [1:0]                    in_octave_shift,
  input  logic                          in_audio_on,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [13:0]                   out_linear_value,
  output logic [13:0]                   out_wave_step,
  output logic                          out_step_valid,
  output logic [11:0]                   out_cv_value,
  output logic                          out_cv_valid,
  output logic [15:0]                   out_volume_level,
  output logic                          out_gate,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import tcc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  tcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  tcc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_capture       (in_capture),
    .in_pitch_pot     (in_pitch_pot),
    .in_volume_pot    (in_volume_pot),
    .in_octave_shift  (in_octave_shift),
    .in_audio_on      (in_audio_on),
    .out_kind         (out_kind),
    .out_linear_value (out_linear_value),
    .out_wave_step    (out_wave_step),
    .out_step_valid   (out_step_valid),
    .out_cv_value     (out_cv_value),
    .out_cv_valid     (out_cv_valid),
    .out_volume_level (out_volume_level),
    .out_gate         (out_gate)
  );

endmodule

[tb/theremin_capture_conditioner_checker.sv]
// Checker for the theremin capture conditioner: shared test types, a result predictor and
// an in-order scoreboard that watches the input, result and register channels.
// Depends on tcc_pkg for the register indexes, CV modes and conditioning constants.
package tcc_tb_pkg;

  typedef enum logic {
    CAP_PITCH  = 1'b0,
    CAP_VOLUME = 1'b1
  } capture_kind_e;

  typedef struct packed {
    logic        kind;
    logic [13:0] linear_value;
    logic [13:0] wave_step;
    logic        step_valid;
    logic [11:0] cv_value;
    logic        cv_valid;
    logic [15:0] volume_level;
    logic        gate;
  } conditioned_t;

endpackage

module theremin_capture_conditioner_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_func,
  input  logic [15:0]                   in_capture,
  input  logic [9:0]                    in_pitch_pot,
  input  logic [9:0]                    in_volume_pot,
  input  logic [1:0]                    in_octave_shift,
  input  logic                          in_audio_on,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_kind,
  input  logic [13:0]                   out_linear_value,
  input  logic [13:0]                   out_wave_step,
  input  logic                          out_step_valid,
  input  logic [11:0]                   out_cv_value,
  input  logic                          out_cv_valid,
  input  logic [15:0]                   out_volume_level,
  input  logic                          out_gate,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcc_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;
  import tcc_tb_pkg::*;

  logic [15:0]  pitch_base;
  logic [15:0]  volume_base;
  logic [1:0]   cv_mode;
  logic [6:0]   gate_on_level;
  logic [6:0]   gate_off_level;

  logic [15:0]  pitch_avg;
  logic [15:0]  volume_avg;
  logic [15:0]  last_volume;
  logic         volume_seen;
  logic         gate_open;

  conditioned_t pending_results[$];

  function automatic logic [15:0] running_average(logic [15:0] avg, logic [15:0] x);
    int d;
    d = int'(x) - int'(avg);
    return 16'(int'(avg) + (d >>> 2));
  endfunction

  function automatic logic [11:0] pitch_log_cv(logic [13:0] lin);
    int unsigned t;
    int unsigned octs;
    int          r;
    t = lin;
    octs = 0;
    while (t > LOG_NORM_MAX) begin
      octs += LOG_OCT;
      t >>= 1;
    end
    t = (t > LOG_KNEE) ? t - LOG_KNEE : 0;
    r = int'(octs) + int'((t * LOG_OCT) >> 9) - LOG_BIAS;
    return (r < 0) ? 12'd0 : 12'(r);
  endfunction

  function automatic string describe(conditioned_t r);
    return $sformatf("kind=%0d lin=%0d step=%0d/%0d cv=%0d/%0d level=%0d gate=%0d",
                     r.kind, r.linear_value, r.wave_step, r.step_valid, r.cv_value,
                     r.cv_valid, r.volume_level, r.gate);
  endfunction

  // Updates the averages, volume history and gate as the block does for one transaction.
  function automatic bit condition_capture(output conditioned_t res);
    int          lin;
    int          diff;
    bit          cv_on;
    logic [15:0] x;
    logic [7:0]  t;
    logic [6:0]  half;
    res = '0;
    res.kind = in_func;
    cv_on = (cv_mode == CV_LINEAR) || (cv_mode == CV_LOG);
    if (in_func == CAP_PITCH) begin
      pitch_avg = running_average(pitch_avg, in_capture);
      lin = int'(pitch_base) - int'(pitch_avg) + PITCH_OFS - 4 * int'(in_pitch_pot);
      if (lin < 0) lin = 0;
      if (lin > PITCH_MAX) lin = PITCH_MAX;
      res.linear_value = 14'(lin);
      if (in_audio_on) begin
        res.wave_step = res.linear_value >> in_octave_shift;
        res.step_valid = 1'b1;
        if (lin != int'(in_capture) && cv_on) begin
          res.cv_value = (cv_mode == CV_LINEAR) ? 12'(lin >> 2)
                                                : pitch_log_cv(res.linear_value);
          res.cv_valid = 1'b1;
        end
      end
    end else begin
      if (volume_seen && in_capture == last_volume) return 1'b0;
      last_volume = in_capture;
      volume_seen = 1'b1;
      x = (in_capture < VOL_FLOOR) ? VOL_FLOOR : in_capture;
      volume_avg = running_average(volume_avg, x);
      diff = int'(volume_base) - int'(volume_avg);
      lin = VOL_MAX - diff / 2 + 4 * int'(in_volume_pot) - VOL_POT_OFS;
      if (lin < 0) lin = 0;
      if (lin > VOL_MAX) lin = VOL_MAX;
      res.linear_value = 14'(lin);
      t = 8'(lin >> 4);
      if (in_audio_on) res.volume_level = 16'(int'(t) * (int'(t) + 2));
      if (cv_on) begin
        res.cv_value = 12'(lin);
        res.cv_valid = 1'b1;
        half = t[7:1];
        if (!gate_open && half >= gate_on_level) begin
          gate_open = 1'b1;
        end else if (gate_open && half <= gate_off_level) begin
          gate_open = 1'b0;
        end
      end
    end
    res.gate = gate_open;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    conditioned_t seen;
    conditioned_t want;
    if (!rst_n) begin
      pitch_base = '0;
      volume_base = '0;
      cv_mode = CV_OFF;
      gate_on_level = GATE_ON_RESET;
      gate_off_level = GATE_OFF_RESET;
      pitch_avg = '0;
      volume_avg = '0;
      last_volume = '0;
      volume_seen = 1'b0;
      gate_open = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_kind, out_linear_value, out_wave_step, out_step_valid, out_cv_value,
                 out_cv_valid, out_volume_level, out_gate};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result at %0t: %s", $time, describe(seen));
          end
        end else begin
          want = pending_results.pop_front();
          if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: expected %s", $time, describe(want));
              $display("                  got      %s", describe(seen));
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (condition_capture(want)) pending_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PITCH_BASE:  pitch_base = cfg_data;
          REG_VOLUME_BASE: volume_base = cfg_data;
          REG_CV_MODE:     cv_mode = cfg_data[1:0];
          REG_GATE_ON:     gate_on_level = cfg_data[6:0];
          REG_GATE_OFF:    gate_off_level = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    outstanding = pending_results.size();
  end

endmodule

[tb/theremin_capture_conditioner_test.sv]
// Top of the theremin capture conditioner test: clock, reset, register settings, directed
// and random captures with random gaps and result stalls, a watchdog and the verdict.
// Depends on tcc_pkg, tcc_tb_pkg, the checker module and the block itself.
module theremin_capture_conditioner_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;
  import tcc_tb_pkg::*;

  localparam logic [1:0]           CV_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int                   QUIET_LIMIT  = 4000;
  localparam int                   PHASE_ITEMS  = 225;
  localparam logic [1:0]           MODE_PLAN [7] =
    '{CV_LINEAR, CV_LOG, CV_OFF, CV_LOG, CV_SPARE, CV_LINEAR, CV_LOG};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = 1'b0;
  logic [15:0]          in_capture = '0;
  logic [9:0]           in_pitch_pot = '0;
  logic [9:0]           in_volume_pot = '0;
  logic [1:0]           in_octave_shift = '0;
  logic                 in_audio_on = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_kind;
  logic [13:0]          out_linear_value;
  logic [13:0]          out_wave_step;
  logic                 out_step_valid;
  logic [11:0]          out_cv_value;
  logic                 out_cv_valid;
  logic [15:0]          out_volume_level;
  logic                 out_gate;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   mismatches;
  int                   outstanding;

  bit                   steady = 1'b0;
  logic [15:0]          last_volume_cap = '0;
  bit                   volume_seen = 1'b0;
  logic                 rx_took = 1'b0;
  int                   rx_hold = 0;
  int                   quiet_cycles = 0;

  theremin_capture_conditioner u_top (.*);

  theremin_capture_conditioner_checker u_checker (.*);

  always #6 clk = ~clk;

  always @(posedge clk) rx_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (rx_took) rx_hold = steady ? 0 : $urandom_range(0, 5);
    if (out_valid && rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] pbase, logic [15:0] vbase, logic [1:0] mode,
                                logic [6:0] on_lvl, logic [6:0] off_lvl);
    write_reg(REG_PITCH_BASE, pbase);
    write_reg(REG_VOLUME_BASE, vbase);
    write_reg(REG_CV_MODE, CFG_DAT_W'(mode));
    write_reg(REG_GATE_ON, CFG_DAT_W'(on_lvl));
    write_reg(REG_GATE_OFF, CFG_DAT_W'(off_lvl));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_capture(capture_kind_e kind, logic [15:0] cap, logic [9:0] ppot,
                              logic [9:0] vpot, logic [1:0] shift, logic audio);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= kind;
    in_capture <= cap;
    in_pitch_pot <= ppot;
    in_volume_pot <= vpot;
    in_octave_shift <= shift;
    in_audio_on <= audio;
    if (kind == CAP_VOLUME) begin
      last_volume_cap = cap;
      volume_seen = 1'b1;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every result is in, then lets a repeated volume capture finish as well.
  task automatic settle();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic send_random_capture(logic [15:0] pbase, logic [15:0] vbase,
                                     output bit was_repeat);
    int            sel;
    int            guess;
    capture_kind_e kind;
    logic [15:0]   cap;
    logic [9:0]    ppot;
    logic [9:0]    vpot;
    logic [1:0]    shift;
    logic          audio;
    ppot = 10'($urandom);
    vpot = 10'($urandom);
    shift = 2'($urandom);
    audio = ($urandom_range(0, 99) < 85);
    kind = ($urandom_range(0, 1) == 1) ? CAP_VOLUME : CAP_PITCH;
    sel = $urandom_range(0, 99);
    if (kind == CAP_PITCH) begin
      guess = int'(pbase) + PITCH_OFS - 4 * int'(ppot) - int'($urandom_range(0, PITCH_MAX));
    end else begin
      guess = int'(vbase)
              - 2 * (VOL_MAX - VOL_POT_OFS + 4 * int'(vpot) - int'($urandom_range(0, VOL_MAX)));
    end
    guess += int'($urandom_range(0, 64)) - 32;
    if (guess < 0) guess = 0;
    if (guess > 65535) guess = 65535;
    cap = 16'(guess);
    if (sel < 15) begin
      cap = 16'($urandom);
    end else if (kind == CAP_VOLUME && sel < 35) begin
      cap = last_volume_cap;
    end
    was_repeat = (kind == CAP_VOLUME) && volume_seen && (cap == last_volume_cap);
    send_capture(kind, cap, ppot, vpot, shift, audio);
  endtask

  initial begin
    logic [15:0] pbase;
    logic [15:0] vbase;
    logic [6:0]  on_lvl;
    logic [6:0]  off_lvl;
    int          counted;
    bit          was_repeat;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    apply_settings(16'd0, 16'd0, CV_LINEAR, GATE_ON_RESET, GATE_OFF_RESET);
    // The first volume transaction must not be taken for a repeat of the zero history.
    send_capture(CAP_VOLUME, 16'd0, 10'd0, 10'd0, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'd0, 10'd0, 10'd0, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'hFFFF, 10'd0, 10'h3FF, 2'd2, 1'b0);
    send_capture(CAP_VOLUME, 16'd4999, 10'd0, 10'd0, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'd5000, 10'd0, 10'h155, 2'd2, 1'b1);
    send_capture(CAP_PITCH, 16'hFFFF, 10'd0, 10'd0, 2'd0, 1'b1);
    // The pitch clamps to zero, equal to the capture, so no CV is given.
    send_capture(CAP_PITCH, 16'd0, 10'd0, 10'd0, 2'd1, 1'b1);
    send_capture(CAP_PITCH, 16'd0, 10'h3FF, 10'h2AA, 2'd1, 1'b1);
    send_capture(CAP_PITCH, 16'd12345, 10'h2AA, 10'd0, 2'd2, 1'b0);
    send_capture(CAP_PITCH, 16'd40000, 10'h155, 10'd0, 2'd3, 1'b1);
    settle();

    apply_settings(16'hFFFF, 16'hFFFF, CV_LOG, 7'd0, 7'd127);
    send_capture(CAP_PITCH, 16'd16383, 10'd0, 10'd0, 2'd2, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_capture(CAP_PITCH, 16'hFFFF, 10'h3FF, 10'd0, 2'(i), 1'b1);
    end
    send_capture(CAP_VOLUME, 16'd30000, 10'd0, 10'd512, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'd30001, 10'd0, 10'd512, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'hFFFF, 10'd0, 10'h3FF, 2'd1, 1'b0);
    settle();

    write_reg(REG_UNMAPPED, 16'hFFFF);
    apply_settings(16'h1234, 16'h8000, CV_SPARE, 7'd127, 7'd0);
    send_capture(CAP_PITCH, 16'd100, 10'd0, 10'd0, 2'd2, 1'b1);
    send_capture(CAP_VOLUME, 16'd7000, 10'd0, 10'd0, 2'd2, 1'b1);
    settle();

    apply_settings(16'h4000, 16'h2000, CV_OFF, GATE_ON_RESET, GATE_OFF_RESET);
    send_capture(CAP_VOLUME, 16'd9000, 10'd0, 10'h3FF, 2'd3, 1'b1);
    send_capture(CAP_PITCH, 16'd2000, 10'd0, 10'd0, 2'd2, 1'b1);
    settle();

    for (int phase = 0; phase < 7; phase++) begin
      pbase = (phase == 0) ? 16'd0 : (phase == 1) ? 16'hFFFF : 16'($urandom);
      vbase = (phase == 2) ? 16'd0 : (phase == 3) ? 16'hFFFF : 16'($urandom);
      on_lvl = (phase == 0) ? 7'd0 : (phase == 1) ? 7'd127 : 7'($urandom);
      off_lvl = (phase == 0) ? 7'd127 : (phase == 1) ? 7'd0 : 7'($urandom);
      apply_settings(pbase, vbase, MODE_PLAN[phase], on_lvl, off_lvl);
      steady = (phase == 1) || (phase == 4);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        send_random_capture(pbase, vbase, was_repeat);
        if (!was_repeat) begin
          counted++;
          if (phase == 3 && counted == PHASE_ITEMS / 2) settle();
        end
      end
      steady = 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
